/* design/pee_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pee_pkg
// shared types, constants and the control store of the prefix evaluator
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MINUS  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_FROZEN = 2'd3
    } mode_t;

    // one stack entry
    typedef struct packed {
        logic              is_number;
        op_t               operator_code;
        logic [DATA_W-1:0] value;
    } entry_t;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_FETCH    = 4'd0,
        ST_SCAN     = 4'd1,
        ST_OP_TEST  = 4'd2,
        ST_NL_TEST  = 4'd3,
        ST_EMIT_ADR = 4'd4,
        ST_EMIT_RD  = 4'd5,
        ST_EMIT     = 4'd6,
        ST_OP_PUSH  = 4'd7,
        ST_NUM_CHK  = 4'd8,
        ST_NUM_RD   = 4'd9,
        ST_NUM_TEST = 4'd10,
        ST_NUM_ALU  = 4'd11,
        ST_NUM_WR   = 4'd12
    } step_t;

    typedef enum logic [2:0] {
        UOP_NOP      = 3'd0,
        UOP_SCAN     = 3'd1,
        UOP_PUSH_OP  = 3'd2,
        UOP_CHK_FULL = 3'd3,
        UOP_REDUCE   = 3'd4,
        UOP_PUSH_NUM = 3'd5,
        UOP_PTR_ONE  = 3'd6,
        UOP_EMIT     = 3'd7
    } uop_t;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN_TAKEN = 3'd1,
        COND_FINISH   = 3'd2,
        COND_OP       = 3'd3,
        COND_NL       = 3'd4,
        COND_FULL     = 3'd5,
        COND_REDUCE   = 3'd6,
        COND_OUT_BUSY = 3'd7
    } cond_t;

    // control word: action, branch test, target when taken, target otherwise
    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t jump;
        step_t next;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        case (step)
            ST_FETCH:    w = '{UOP_NOP,      COND_IN_TAKEN, ST_SCAN,     ST_FETCH};
            ST_SCAN:     w = '{UOP_SCAN,     COND_FINISH,   ST_NUM_CHK,  ST_OP_TEST};
            ST_OP_TEST:  w = '{UOP_NOP,      COND_OP,       ST_OP_PUSH,  ST_NL_TEST};
            ST_NL_TEST:  w = '{UOP_NOP,      COND_NL,       ST_EMIT_ADR, ST_FETCH};
            ST_EMIT_ADR: w = '{UOP_PTR_ONE,  COND_ALWAYS,   ST_EMIT_RD,  ST_EMIT_RD};
            ST_EMIT_RD:  w = '{UOP_NOP,      COND_ALWAYS,   ST_EMIT,     ST_EMIT};
            ST_EMIT:     w = '{UOP_EMIT,     COND_OUT_BUSY, ST_EMIT,     ST_FETCH};
            ST_OP_PUSH:  w = '{UOP_PUSH_OP,  COND_ALWAYS,   ST_NL_TEST,  ST_NL_TEST};
            ST_NUM_CHK:  w = '{UOP_CHK_FULL, COND_FULL,     ST_NL_TEST,  ST_NUM_TEST};
            ST_NUM_RD:   w = '{UOP_NOP,      COND_ALWAYS,   ST_NUM_TEST, ST_NUM_TEST};
            ST_NUM_TEST: w = '{UOP_NOP,      COND_REDUCE,   ST_NUM_ALU,  ST_NUM_WR};
            ST_NUM_ALU:  w = '{UOP_REDUCE,   COND_ALWAYS,   ST_NUM_RD,   ST_NUM_RD};
            ST_NUM_WR:   w = '{UOP_PUSH_NUM, COND_ALWAYS,   ST_NL_TEST,  ST_NL_TEST};
            default:     w = '{UOP_NOP,      COND_ALWAYS,   ST_FETCH,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* design/prefix_expression_evaluator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_top
// evaluates prefix expressions streamed one text byte at a time
// ----------------------------------------------------------------------------
// The block reads prefix text one byte per input transfer and gives one result
// transfer per newline: the value of the bottom stack entry (zero if the stack
// is empty or holds an operator there) and a flag telling whether a push was
// refused for lack of room during that line. A short microprogram in a
// read-only control store sequences a plain datapath over a stack memory of
// pee_pkg::STACK_DEPTH entries with two registered read ports. A byte that
// finishes a number walks the stack, folding every operator/number pair below
// it; a number is dropped if the stack is full. A newline reads the bottom entry
// and loads the output register, waiting while that register still holds an
// unaccepted result. Each fold waits for the registered stack read, tests, and
// uses the adder or multiplier. The input is taken only between bytes; the
// output register lets the next byte enter while a result waits. The stack
// needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_top (
    input  wire  logic                                clk,
    input  wire  logic                                rst_n,
    input  wire  logic                                in_valid,
    output       logic                                in_stall,
    input  wire  logic [pee_pkg::CHAR_W-1:0]          text_byte,
    output       logic                                out_valid,
    input  wire  logic                                out_stall,
    output       logic signed [pee_pkg::DATA_W-1:0]   expression_value,
    output       logic                                stack_overflowed
);

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    pee_pkg::step_t upc_reg, upc_next;
    pee_pkg::ctrl_t ctrl;
    logic           cond_true;

    // scanner state
    logic [pee_pkg::CHAR_W-1:0] byte_reg, byte_next;
    pee_pkg::mode_t             mode_reg, mode_next;
    logic [pee_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic                       op_pend_reg, op_pend_next;
    pee_pkg::op_t               pend_op_reg, pend_op_next;
    logic                       nl_reg, nl_next;
    logic                       ovf_reg, ovf_next;

    // stack pointers and the value being folded
    logic [pee_pkg::PTR_W-1:0]  top_reg, top_next;
    logic [pee_pkg::PTR_W-1:0]  ptr_reg, ptr_next;
    logic [pee_pkg::DATA_W-1:0] val_reg, val_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [pee_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic                       out_ovf_reg, out_ovf_next;

    // stack memory
    pee_pkg::entry_t            stack_mem [pee_pkg::STACK_DEPTH];
    pee_pkg::entry_t            rd_a_reg;
    pee_pkg::entry_t            rd_b_reg;
    logic [pee_pkg::ADDR_W-1:0] addr_a;
    logic [pee_pkg::ADDR_W-1:0] addr_b;
    logic [pee_pkg::PTR_W-1:0]  ptr_m1;
    logic [pee_pkg::PTR_W-1:0]  ptr_m2;
    logic                       wr_en;
    logic [pee_pkg::ADDR_W-1:0] wr_addr;
    pee_pkg::entry_t            wr_data;

    // byte decode
    logic                       is_space;
    logic                       is_nl;
    logic                       is_digit;
    logic [pee_pkg::CHAR_W-1:0] digit_raw;
    logic [pee_pkg::DATA_W-1:0] digit_val;
    logic [pee_pkg::DATA_W-1:0] acc_x10;
    logic                       finish_num;
    logic [pee_pkg::DATA_W-1:0] finish_val;
    logic [pee_pkg::DATA_W-1:0] fold_val;

    // handshake helpers
    logic                       in_fire;
    logic                       out_busy;
    logic                       emit_fire;
    logic                       stack_full;
    logic                       can_reduce;

    // ------------------------------------------------------------------
    // byte decode, all from the latched byte, the current scan mode and the number being built
    // ------------------------------------------------------------------
    always_comb
    begin
        is_space   = (byte_reg == pee_pkg::CHAR_SPACE);
        is_nl      = (byte_reg == pee_pkg::CHAR_NL);
        is_digit   = (byte_reg >= pee_pkg::CHAR_ZERO) && (byte_reg <= pee_pkg::CHAR_NINE);
        digit_raw  = byte_reg - pee_pkg::CHAR_ZERO;
        digit_val  = pee_pkg::DATA_W'(digit_raw);
        // times ten plus the digit as two shifts and two adds, wrapping at the data width
        acc_x10    = (acc_reg << 3) + (acc_reg << 1) + digit_val;
        finish_num = ((mode_reg == pee_pkg::MODE_MINUS) && is_nl) ||
                     (((mode_reg == pee_pkg::MODE_NUMBER) ||
                       (mode_reg == pee_pkg::MODE_FROZEN)) && (is_space || is_nl));
        // a lone minus before newline pushes zero
        if (mode_reg == pee_pkg::MODE_MINUS)
            finish_val = '0;
        else if (neg_reg)
            finish_val = '0 - acc_reg;
        else
            finish_val = acc_reg;
    end

    // ------------------------------------------------------------------
    // stack addressing: port a sees the entry just below the pointer,
    // port b the one below that
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_m1 = ptr_reg - pee_pkg::PTR_W'(1);
        ptr_m2 = ptr_reg - pee_pkg::PTR_W'(2);
        addr_a = (ptr_reg >= pee_pkg::PTR_W'(1)) ? ptr_m1[pee_pkg::ADDR_W-1:0]
                                                  : pee_pkg::ADDR_W'(0);
        addr_b = (ptr_reg >= pee_pkg::PTR_W'(2)) ? ptr_m2[pee_pkg::ADDR_W-1:0]
                                                  : pee_pkg::ADDR_W'(0);
    end

    always_comb
    begin
        stack_full = (top_reg >= pee_pkg::PTR_W'(pee_pkg::STACK_DEPTH));
        // fold while a number sits on an operator
        can_reduce = (ptr_reg >= pee_pkg::PTR_W'(2)) && rd_a_reg.is_number &&
                     !rd_b_reg.is_number &&
                     ((rd_b_reg.operator_code == pee_pkg::OP_ADD) ||
                      (rd_b_reg.operator_code == pee_pkg::OP_SUB) ||
                      (rd_b_reg.operator_code == pee_pkg::OP_MUL));
        case (rd_b_reg.operator_code)
            pee_pkg::OP_ADD: fold_val = rd_a_reg.value + val_reg;
            pee_pkg::OP_SUB: fold_val = rd_a_reg.value - val_reg;
            pee_pkg::OP_MUL: fold_val = rd_a_reg.value * val_reg;
            default:         fold_val = val_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // control store and branch test
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl      = pee_pkg::ucode(upc_reg);
        in_stall  = (upc_reg != pee_pkg::ST_FETCH);
        in_fire   = in_valid && !in_stall;
        out_busy  = out_valid_reg && out_stall;
        emit_fire = (ctrl.uop == pee_pkg::UOP_EMIT) && !out_busy;
        case (ctrl.cond)
            pee_pkg::COND_ALWAYS:   cond_true = 1'b1;
            pee_pkg::COND_IN_TAKEN: cond_true = in_fire;
            pee_pkg::COND_FINISH:   cond_true = finish_num;
            pee_pkg::COND_OP:       cond_true = op_pend_reg;
            pee_pkg::COND_NL:       cond_true = nl_reg;
            pee_pkg::COND_FULL:     cond_true = stack_full;
            pee_pkg::COND_REDUCE:   cond_true = can_reduce;
            pee_pkg::COND_OUT_BUSY: cond_true = out_busy;
            default:                cond_true = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        upc_next = cond_true ? ctrl.jump : ctrl.next;
    end

    // ------------------------------------------------------------------
    // datapath actions driven by the control word
    // ------------------------------------------------------------------
    always_comb
    begin
        byte_next      = in_fire ? text_byte : byte_reg;
        mode_next      = mode_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        op_pend_next   = op_pend_reg;
        pend_op_next   = pend_op_reg;
        nl_next        = nl_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        ptr_next       = ptr_reg;
        val_next       = val_reg;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_busy;
        wr_en          = 1'b0;
        wr_addr        = top_reg[pee_pkg::ADDR_W-1:0];
        wr_data        = '{1'b0, pee_pkg::OP_ADD, '0};

        case (ctrl.uop)
            pee_pkg::UOP_SCAN:
            begin
                ptr_next     = top_reg;
                val_next     = finish_val;
                nl_next      = is_nl;
                op_pend_next = 1'b0;
                case (mode_reg)
                    pee_pkg::MODE_MINUS:
                    begin
                        if (is_space)
                        begin
                            op_pend_next = 1'b1;
                            pend_op_next = pee_pkg::OP_SUB;
                            mode_next    = pee_pkg::MODE_IDLE;
                        end
                        else if (is_nl)
                        begin
                            acc_next  = '0;
                            neg_next  = 1'b0;
                            mode_next = pee_pkg::MODE_IDLE;
                        end
                        else if (is_digit)
                        begin
                            acc_next  = digit_val;
                            neg_next  = 1'b1;
                            mode_next = pee_pkg::MODE_NUMBER;
                        end
                        else
                        begin
                            acc_next  = '0;
                            neg_next  = 1'b1;
                            mode_next = pee_pkg::MODE_FROZEN;
                        end
                    end
                    pee_pkg::MODE_NUMBER, pee_pkg::MODE_FROZEN:
                    begin
                        if (is_space || is_nl)
                        begin
                            acc_next  = '0;
                            neg_next  = 1'b0;
                            mode_next = pee_pkg::MODE_IDLE;
                        end
                        else if ((mode_reg == pee_pkg::MODE_NUMBER) && is_digit)
                            acc_next = acc_x10;
                        else
                            mode_next = pee_pkg::MODE_FROZEN;
                    end
                    default:
                    begin
                        // idle: other characters are ignored
                        if (byte_reg == pee_pkg::CHAR_PLUS)
                        begin
                            op_pend_next = 1'b1;
                            pend_op_next = pee_pkg::OP_ADD;
                        end
                        else if (byte_reg == pee_pkg::CHAR_STAR)
                        begin
                            op_pend_next = 1'b1;
                            pend_op_next = pee_pkg::OP_MUL;
                        end
                        else if (byte_reg == pee_pkg::CHAR_MINUS)
                            mode_next = pee_pkg::MODE_MINUS;
                        else if (is_digit)
                        begin
                            acc_next  = digit_val;
                            neg_next  = 1'b0;
                            mode_next = pee_pkg::MODE_NUMBER;
                        end
                    end
                endcase
            end
            pee_pkg::UOP_PUSH_OP:
            begin
                if (stack_full)
                    ovf_next = 1'b1;
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = top_reg[pee_pkg::ADDR_W-1:0];
                    wr_data  = '{1'b0, pend_op_reg, '0};
                    top_next = top_reg + pee_pkg::PTR_W'(1);
                end
            end
            pee_pkg::UOP_CHK_FULL:
            begin
                if (stack_full)
                    ovf_next = 1'b1;
            end
            pee_pkg::UOP_REDUCE:
            begin
                val_next = fold_val;
                ptr_next = ptr_m2;
            end
            pee_pkg::UOP_PUSH_NUM:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[pee_pkg::ADDR_W-1:0];
                wr_data  = '{1'b1, pee_pkg::OP_ADD, val_reg};
                top_next = ptr_reg + pee_pkg::PTR_W'(1);
            end
            pee_pkg::UOP_PTR_ONE:
            begin
                // points port a at the bottom entry
                ptr_next = pee_pkg::PTR_W'(1);
            end
            pee_pkg::UOP_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ((top_reg != '0) && rd_a_reg.is_number) ?
                                     rd_a_reg.value : '0;
                    out_ovf_next   = ovf_reg;
                    top_next       = '0;
                    acc_next       = '0;
                    neg_next       = 1'b0;
                    mode_next      = pee_pkg::MODE_IDLE;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= pee_pkg::ST_FETCH;
            mode_reg      <= pee_pkg::MODE_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            op_pend_reg   <= 1'b0;
            nl_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            op_pend_reg   <= op_pend_next;
            nl_reg        <= nl_next;
            ovf_reg       <= ovf_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        pend_op_reg   <= pend_op_next;
        ptr_reg       <= ptr_next;
        val_reg       <= val_next;
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        rd_a_reg <= stack_mem[addr_a];
        rd_b_reg <= stack_mem[addr_b];
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign out_valid        = out_valid_reg;
    assign expression_value = $signed(out_value_reg);
    assign stack_overflowed = out_ovf_reg;

endmodule
`default_nettype wire
